// ===== hw/rtl/bbosp_pkg.sv =====
`default_nettype none
package bbosp_pkg;

    localparam int ORBIT_SLOTS = 32;
    localparam int SLOT_W      = $clog2(ORBIT_SLOTS);
    localparam int FRAC_BITS   = 27;
    localparam int CNT_W       = 17;
    localparam int MAX_SIDE    = 4096;

    localparam logic signed [31:0] ESCAPE_LIM = 32'sd1 <<< (FRAC_BITS + 1);

    localparam logic [2:0] REG_VIEW_LEFT  = 3'd0;
    localparam logic [2:0] REG_VIEW_TOP   = 3'd1;
    localparam logic [2:0] REG_SCALE_X    = 3'd2;
    localparam logic [2:0] REG_SCALE_Y    = 3'd3;
    localparam logic [2:0] REG_PIC_WIDTH  = 3'd4;
    localparam logic [2:0] REG_PIC_HEIGHT = 3'd5;
    localparam logic [2:0] REG_ITER_LIMIT = 3'd6;
    localparam logic [2:0] REG_REC_START  = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_POST,
        ST_RD,
        ST_DIFF,
        ST_PROD,
        ST_PIX,
        ST_IDX,
        ST_HIT,
        ST_FLUSH
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_MUL,
        OP_UPD,
        OP_RD,
        OP_DIFF,
        OP_PROD,
        OP_PIX,
        OP_IDX,
        OP_HIT,
        OP_FLUSH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic escape;
        logic cnt_ge_max;
        logic slot_last;
        logic hit;
        logic pend_valid;
        logic out_free;
    } sts_t;

    typedef struct packed {
        logic signed [31:0] view_left;
        logic signed [31:0] view_top;
        logic [31:0]        scale_x;
        logic [31:0]        scale_y;
        logic [12:0]        pic_width;
        logic [12:0]        pic_height;
        logic [15:0]        iter_limit;
        logic [15:0]        rec_start;
    } cfg_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bbosp_ctrl.sv =====
`default_nettype none
module bbosp_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    input  wire logic          in_enabled,
    output logic               in_ready,
    input  wire bbosp_pkg::sts_t sts,
    output bbosp_pkg::cmd_t    cmd
);
    import bbosp_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid && in_enabled) begin
                    cmd.op     = OP_START;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.op     = OP_MUL;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                cmd.op = OP_UPD;
                if (sts.escape || sts.cnt_ge_max) begin
                    state_next = ST_POST;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_POST: begin
                state_next = sts.cnt_ge_max ? ST_IDLE : ST_RD;
            end
            ST_RD: begin
                cmd.op     = OP_RD;
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                cmd.op     = OP_DIFF;
                state_next = ST_PROD;
            end
            ST_PROD: begin
                cmd.op     = OP_PROD;
                state_next = ST_PIX;
            end
            ST_PIX: begin
                cmd.op     = OP_PIX;
                state_next = ST_IDX;
            end
            ST_IDX: begin
                cmd.op     = OP_IDX;
                state_next = ST_HIT;
            end
            ST_HIT: begin
                if (!(sts.hit && sts.pend_valid && !sts.out_free)) begin
                    cmd.op     = OP_HIT;
                    state_next = sts.slot_last ? ST_FLUSH : ST_RD;
                end
            end
            ST_FLUSH: begin
                if (!sts.pend_valid) begin
                    state_next = ST_IDLE;
                end else if (sts.out_free) begin
                    cmd.op     = OP_FLUSH;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/bbosp_dp.sv =====
`default_nettype none
module bbosp_dp (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire bbosp_pkg::cmd_t cmd,
    output bbosp_pkg::sts_t      sts,
    input  wire bbosp_pkg::cfg_t cfg,
    input  wire logic [63:0]     in_data,
    output logic [23:0]          out_pixel_index,
    output logic [16:0]          out_iter_add,
    output logic                 out_last,
    output logic                 out_valid,
    input  wire logic            out_ready
);
    import bbosp_pkg::*;

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        logic signed [31:0] r;
        if (v > 38'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -38'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    logic signed [31:0] c_re_reg, c_im_reg, z_re_reg, z_im_reg;
    logic signed [63:0] aa_reg, bb_reg, ab_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic signed [31:0] orb_re [ORBIT_SLOTS];
    logic signed [31:0] orb_im [ORBIT_SLOTS];
    logic [ORBIT_SLOTS-1:0] valid_reg;

    logic signed [31:0] rd_re_reg, rd_im_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic               negx_reg, negy_reg;
    logic [48:0]        hix_reg, lox_reg, hiy_reg, loy_reg;
    logic [11:0]        px_reg, py_reg;
    logic               hit_reg;
    logic [23:0]        idx_reg;
    logic [16:0]        add_reg;
    logic [23:0]        pend_idx_reg;
    logic [16:0]        pend_add_reg;
    logic               pend_valid_reg;
    logic [23:0]        out_idx_reg;
    logic [16:0]        out_add_reg;
    logic               out_last_reg, out_valid_reg;

    logic signed [63:0] rr;
    logic signed [37:0] re_sum, im_sum;
    logic signed [31:0] re_new, im_new;
    logic               escape;
    logic [CNT_W:0]     off_diff;
    logic               in_slice;
    logic [12:0]        w, h;
    logic [49:0]        sumx, sumy;
    logic [22:0]        vx, vy;
    logic               out_free;

    assign rr       = aa_reg - bb_reg;
    assign re_sum   = 38'(rr >>> FRAC_BITS) + 38'(c_re_reg);
    assign im_sum   = 38'(ab_reg >>> (FRAC_BITS - 1)) + 38'(c_im_reg);
    assign re_new   = sat32(re_sum);
    assign im_new   = sat32(im_sum);
    assign escape   = !(re_new > -ESCAPE_LIM && re_new < ESCAPE_LIM &&
                        im_new > -ESCAPE_LIM && im_new < ESCAPE_LIM);
    assign off_diff = {1'b0, cnt_reg} - (CNT_W + 1)'(cfg.rec_start);
    assign in_slice = !off_diff[CNT_W] && (off_diff < (CNT_W + 1)'(ORBIT_SLOTS));

    assign w    = (cfg.pic_width > 13'(MAX_SIDE)) ? 13'(MAX_SIDE) : cfg.pic_width;
    assign h    = (cfg.pic_height > 13'(MAX_SIDE)) ? 13'(MAX_SIDE) : cfg.pic_height;
    assign sumx = 50'(hix_reg) + 50'(lox_reg >> 16);
    assign sumy = 50'(hiy_reg) + 50'(loy_reg >> 16);
    assign vx   = 23'(sumx >> FRAC_BITS);
    assign vy   = 23'(sumy >> FRAC_BITS);

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_START: begin
                c_re_reg <= in_data[31:0];
                c_im_reg <= in_data[63:32];
                z_re_reg <= '0;
                z_im_reg <= '0;
                cnt_reg  <= '0;
                slot_reg <= '0;
            end
            OP_MUL: begin
                aa_reg <= z_re_reg * z_re_reg;
                bb_reg <= z_im_reg * z_im_reg;
                ab_reg <= z_re_reg * z_im_reg;
            end
            OP_UPD: begin
                z_re_reg <= re_new;
                z_im_reg <= im_new;
                if (in_slice) begin
                    orb_re[off_diff[SLOT_W-1:0]] <= re_new;
                    orb_im[off_diff[SLOT_W-1:0]] <= im_new;
                end
                if (!escape) begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
            OP_RD: begin
                rd_re_reg <= valid_reg[slot_reg] ? orb_re[slot_reg] : '0;
                rd_im_reg <= valid_reg[slot_reg] ? orb_im[slot_reg] : '0;
            end
            OP_DIFF: begin
                dx_reg <= {rd_re_reg[31], rd_re_reg} - {cfg.view_left[31], cfg.view_left};
                dy_reg <= {rd_im_reg[31], rd_im_reg} - {cfg.view_top[31], cfg.view_top};
            end
            OP_PROD: begin
                negx_reg <= dx_reg[32];
                negy_reg <= dy_reg[32];
                hix_reg  <= dx_reg[32:0] * cfg.scale_x[31:16];
                lox_reg  <= dx_reg[32:0] * cfg.scale_x[15:0];
                hiy_reg  <= dy_reg[32:0] * cfg.scale_y[31:16];
                loy_reg  <= dy_reg[32:0] * cfg.scale_y[15:0];
            end
            OP_PIX: begin
                px_reg <= vx[11:0];
                py_reg <= vy[11:0];
            end
            OP_IDX: begin
                idx_reg <= 24'(25'(py_reg * w) + 25'(px_reg));
                add_reg <= cnt_reg - CNT_W'(slot_reg);
            end
            OP_HIT: begin
                slot_reg <= slot_reg + SLOT_W'(1);
                if (hit_reg) begin
                    pend_idx_reg <= idx_reg;
                    pend_add_reg <= add_reg;
                end
            end
            default: begin
            end
        endcase
        if ((cmd.op == OP_HIT && hit_reg && pend_valid_reg) || cmd.op == OP_FLUSH) begin
            out_idx_reg  <= pend_idx_reg;
            out_add_reg  <= pend_add_reg;
            out_last_reg <= (cmd.op == OP_FLUSH);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            hit_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.op == OP_START) begin
                valid_reg <= '0;
            end else if (cmd.op == OP_UPD && in_slice) begin
                valid_reg[off_diff[SLOT_W-1:0]] <= 1'b1;
            end
            if (cmd.op == OP_PIX) begin
                hit_reg <= !negx_reg && (vx < 23'(w)) && !negy_reg && (vy < 23'(h));
            end
            if (cmd.op == OP_HIT && hit_reg) begin
                pend_valid_reg <= 1'b1;
            end else if (cmd.op == OP_FLUSH) begin
                pend_valid_reg <= 1'b0;
            end
            if ((cmd.op == OP_HIT && hit_reg && pend_valid_reg) || cmd.op == OP_FLUSH) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.escape     = escape;
    assign sts.cnt_ge_max = cnt_reg >= CNT_W'(cfg.iter_limit);
    assign sts.slot_last  = (slot_reg == SLOT_W'(ORBIT_SLOTS - 1));
    assign sts.hit        = hit_reg;
    assign sts.pend_valid = pend_valid_reg;
    assign sts.out_free   = out_free;

    assign out_pixel_index = out_idx_reg;
    assign out_iter_add    = out_add_reg;
    assign out_last        = out_last_reg;
    assign out_valid       = out_valid_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/buddhabrot_orbit_slice_plotter.sv =====
// Orbit slice plotter for density rendering of escaping orbits.
// Input stream (s_): one sample point per transfer, c_real/c_imag in tdata,
// enable bit in tuser. A disabled sample is taken while idle, no output.
// An enabled sample iterates z = z*z + c (the three 32x32 products, then
// sum and saturate) for up to the iteration limit + 1 iterations. If the
// orbit escapes below the limit, the 32 recorded slots are mapped to pixels
// one slot at a time (read, offset, scale products, floor and range check,
// index, handoff).
// Output stream (m_): pixel_index and the iteration add value in tdata, tlast
// on the final hit of the sample. One hit is held back so tlast can be set.
// A stalled receiver holds the output register and pauses the slot sweep;
// the iteration itself does not wait on it.
// Configuration: write cfg_wr_en/cfg_index/cfg_data while idle only.
// Reset (aresetn low, synchronous) restores register defaults and drops
// any sample in flight and any pending output.
`default_nettype none
module buddhabrot_orbit_slice_plotter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // c_real[31:0], c_imag[63:32]
    input  wire logic [0:0]  s_tuser,   // sample_enabled[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // pixel_index[23:0], iteration add[40:24], zero
    output logic             m_tlast,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import bbosp_pkg::*;

    cfg_t        cfg_reg;
    cmd_t        cmd;
    sts_t        sts;
    logic [23:0] pixel_index;
    logic [16:0] iter_add;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.view_left  <= -32'sd268435456;
            cfg_reg.view_top   <= -32'sd268435456;
            cfg_reg.scale_x    <= 32'd16777216;
            cfg_reg.scale_y    <= 32'd16777216;
            cfg_reg.pic_width  <= 13'd1024;
            cfg_reg.pic_height <= 13'd1024;
            cfg_reg.iter_limit <= 16'd1000;
            cfg_reg.rec_start  <= 16'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_VIEW_LEFT:  cfg_reg.view_left  <= cfg_data;
                REG_VIEW_TOP:   cfg_reg.view_top   <= cfg_data;
                REG_SCALE_X:    cfg_reg.scale_x    <= cfg_data;
                REG_SCALE_Y:    cfg_reg.scale_y    <= cfg_data;
                REG_PIC_WIDTH:  cfg_reg.pic_width  <= cfg_data[12:0];
                REG_PIC_HEIGHT: cfg_reg.pic_height <= cfg_data[12:0];
                REG_ITER_LIMIT: cfg_reg.iter_limit <= cfg_data[15:0];
                REG_REC_START:  cfg_reg.rec_start  <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    bbosp_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_enabled (s_tuser[0]),
        .in_ready   (s_tready),
        .sts        (sts),
        .cmd        (cmd)
    );

    bbosp_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .cfg             (cfg_reg),
        .in_data         (s_tdata),
        .out_pixel_index (pixel_index),
        .out_iter_add    (iter_add),
        .out_last        (m_tlast),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready)
    );

    assign m_tdata = {7'd0, iter_add, pixel_index};

endmodule
`default_nettype wire

// ===== hw/rtl/bbosp_checker.sv =====
`default_nettype none
module bbosp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [0:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic        m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output transfer dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output payload changed while stalled");

    a_skip_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser[0] |=> s_tready)
        else $error("disabled sample did not return to idle");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
        else $error("enabled sample did not start iterating");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind buddhabrot_orbit_slice_plotter bbosp_checker u_bbosp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bbosp_pkg::*;

    typedef struct {
        logic [31:0] c_re;
        logic [31:0] c_im;
        logic        en;
    } sample_t;

    typedef struct {
        logic [23:0] pixel;
        logic [16:0] add;
        logic        last;
    } hit_t;

    localparam longint ESC_LIM = longint'(2) <<< FRAC_BITS;
    localparam int STALL_LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = REG_VIEW_LEFT;
    logic [31:0] cfg_data = '0;

    sample_t pending_samples[$];
    hit_t    expected_hits[$];
    int      fails = 0;
    int      quiet_cycles = 0;
    bit      no_gaps = 1'b0;

    longint      view_left = -268435456;
    longint      view_top = -268435456;
    logic [31:0] scale_x = 32'd16777216;
    logic [31:0] scale_y = 32'd16777216;
    logic [12:0] pic_width = 13'd1024;
    logic [12:0] pic_height = 13'd1024;
    logic [15:0] iter_limit = 16'd1000;
    logic [15:0] rec_start = 16'd0;

    buddhabrot_orbit_slice_plotter dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic bit axis_pixel(longint p, longint edge_pos, logic [31:0] scale,
                                      longint size, output longint pix);
        longint diff;
        longint hi;
        longint lo;
        longint v;
        diff = p - edge_pos;
        if (diff < 0) return 1'b0;
        hi = longint'(scale[31:16]);
        lo = longint'(scale[15:0]);
        v = (diff * hi + ((diff * lo) >>> 16)) >>> FRAC_BITS;
        if (v >= size) return 1'b0;
        pix = v;
        return 1'b1;
    endfunction

    task automatic plot_orbit(sample_t smp);
        longint orb_re[ORBIT_SLOTS];
        longint orb_im[ORBIT_SLOTS];
        longint zr, zi, cr, ci, a, b, slot, w, h, px, py;
        int     cnt;
        int     first;
        hit_t   hit;
        if (!smp.en) return;
        cr = longint'(signed'(smp.c_re));
        ci = longint'(signed'(smp.c_im));
        w = (pic_width > 13'd4096) ? 4096 : longint'(pic_width);
        h = (pic_height > 13'd4096) ? 4096 : longint'(pic_height);
        foreach (orb_re[i]) begin
            orb_re[i] = 0;
            orb_im[i] = 0;
        end
        zr = 0;
        zi = 0;
        cnt = 0;
        forever begin
            a = zr;
            b = zi;
            zr = clamp32(((a * a - b * b) >>> FRAC_BITS) + cr);
            zi = clamp32(((a * b) >>> (FRAC_BITS - 1)) + ci);
            slot = longint'(cnt) - longint'(rec_start);
            if (slot >= 0 && slot < ORBIT_SLOTS) begin
                orb_re[slot] = zr;
                orb_im[slot] = zi;
            end
            if (!(zr > -ESC_LIM && zr < ESC_LIM && zi > -ESC_LIM && zi < ESC_LIM)) break;
            if (cnt >= int'(iter_limit)) begin
                cnt++;
                break;
            end
            cnt++;
        end
        if (cnt >= int'(iter_limit)) return;
        first = expected_hits.size();
        for (int s = 0; s < ORBIT_SLOTS; s++) begin
            if (!axis_pixel(orb_re[s], view_left, scale_x, w, px)) continue;
            if (!axis_pixel(orb_im[s], view_top, scale_y, h, py)) continue;
            hit.pixel = 24'(py * w + px);
            hit.add = 17'(cnt - s);
            hit.last = 1'b0;
            expected_hits.push_back(hit);
        end
        if (expected_hits.size() > first) expected_hits[$].last = 1'b1;
    endtask

    always @(posedge aclk) begin
        sample_t taken;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                taken.c_re = s_tdata[31:0];
                taken.c_im = s_tdata[63:32];
                taken.en = s_tuser[0];
                plot_orbit(taken);
            end
            if (!s_tvalid || s_tready) begin
                if (pending_samples.size() > 0 && (no_gaps || $urandom_range(99) >= 18)) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {pending_samples[0].c_im, pending_samples[0].c_re};
                    s_tuser <= pending_samples[0].en;
                    void'(pending_samples.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        hit_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_hits.size() == 0) begin
                $display("%0t: unexpected hit pixel=%0d add=%0d last=%0b", $time,
                         m_tdata[23:0], m_tdata[40:24], m_tlast);
                fails++;
            end else begin
                want = expected_hits.pop_front();
                if (m_tdata[23:0] !== want.pixel) begin
                    $display("%0t: pixel_index expected %0d actual %0d", $time,
                             want.pixel, m_tdata[23:0]);
                    fails++;
                end
                if (m_tdata[40:24] !== want.add) begin
                    $display("%0t: iteration add expected %0d actual %0d", $time,
                             want.add, m_tdata[40:24]);
                    fails++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: last_hit expected %0b actual %0b", $time,
                             want.last, m_tlast);
                    fails++;
                end
            end
        end
        m_tready <= no_gaps || ($urandom_range(99) >= 18);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic drain();
        do begin
            @(negedge aclk);
        end while (pending_samples.size() != 0 || s_tvalid || !s_tready || m_tvalid ||
                   expected_hits.size() != 0);
        @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_VIEW_LEFT:  view_left = longint'(signed'(val));
            REG_VIEW_TOP:   view_top = longint'(signed'(val));
            REG_SCALE_X:    scale_x = val;
            REG_SCALE_Y:    scale_y = val;
            REG_PIC_WIDTH:  pic_width = val[12:0];
            REG_PIC_HEIGHT: pic_height = val[12:0];
            REG_ITER_LIMIT: iter_limit = val[15:0];
            REG_REC_START:  rec_start = val[15:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic add_sample(logic [31:0] re, logic [31:0] im, logic en);
        sample_t smp;
        smp.c_re = re;
        smp.c_im = im;
        smp.en = en;
        pending_samples.push_back(smp);
    endtask

    task automatic add_random(int n);
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                add_sample(32'($urandom_range(375809638)) - 32'd295279001,
                           32'($urandom_range(348966092)) - 32'd174483046, 1'b1);
            end else if (pick < 90) begin
                add_sample($urandom, $urandom, 1'b1);
            end else begin
                add_sample($urandom, $urandom, 1'b0);
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        add_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        add_sample(32'h8000_0000, 32'h8000_0000, 1'b1);
        add_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        add_sample(32'h0000_0000, 32'h0000_0000, 1'b1);
        add_sample(32'hF000_0000, 32'h0000_0000, 1'b1);
        add_sample(32'h0800_0000, 32'h0800_0000, 1'b1);
        add_sample(32'hF9FF_FFFF, 32'h00CC_CCCD, 1'b1);
        add_sample(32'h0200_0000, 32'h0000_0001, 1'b1);
        add_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
        add_sample(32'hEFFF_FFFF, 32'h1000_0000, 1'b1);
        add_sample(32'h0C00_0000, 32'hF400_0000, 1'b1);
        add_random(30);
        drain();

        no_gaps = 1'b1;
        write_reg(REG_ITER_LIMIT, 32'd60);
        write_reg(REG_SCALE_X, 32'h0400_0000);
        write_reg(REG_SCALE_Y, 32'h0400_0000);
        write_reg(REG_VIEW_LEFT, 32'hEC00_0000);
        write_reg(REG_VIEW_TOP, 32'hF000_0000);
        write_reg(REG_PIC_WIDTH, 32'd4096);
        write_reg(REG_PIC_HEIGHT, 32'd4096);
        add_random(40);
        drain();

        no_gaps = 1'b0;
        write_reg(REG_ITER_LIMIT, 32'd200);
        write_reg(REG_REC_START, 32'd3);
        write_reg(REG_PIC_WIDTH, 32'd8191);
        write_reg(REG_PIC_HEIGHT, 32'd0);
        write_reg(REG_SCALE_X, 32'hFFFF_FFFF);
        write_reg(REG_VIEW_LEFT, 32'h8000_0000);
        write_reg(REG_VIEW_TOP, 32'h7FFF_FFFF);
        add_random(8);
        drain();

        write_reg(REG_ITER_LIMIT, 32'd65535);
        write_reg(REG_REC_START, 32'd65535);
        write_reg(REG_VIEW_TOP, 32'h8000_0000);
        write_reg(REG_SCALE_X, 32'd0);
        write_reg(REG_SCALE_Y, 32'd0);
        write_reg(REG_PIC_WIDTH, 32'd1);
        write_reg(REG_PIC_HEIGHT, 32'd1);
        add_sample(32'h1800_0000, 32'h0000_0000, 1'b1);
        add_sample(32'h8000_0000, $urandom, 1'b1);
        add_sample($urandom, 32'h7FFF_FFFF, 1'b1);
        add_sample(32'hF000_0000, 32'h0000_0000, 1'b1);
        add_sample(32'h1000_0000, 32'hEFFF_FFFF, 1'b1);
        drain();

        write_reg(REG_ITER_LIMIT, 32'd0);
        write_reg(REG_REC_START, 32'd0);
        write_reg(REG_VIEW_LEFT, 32'hF000_0000);
        write_reg(REG_VIEW_TOP, 32'hF000_0000);
        write_reg(REG_SCALE_X, 32'h0100_0000);
        write_reg(REG_SCALE_Y, 32'h0100_0000);
        write_reg(REG_PIC_WIDTH, 32'd1024);
        write_reg(REG_PIC_HEIGHT, 32'd1024);
        add_random(5);
        drain();

        write_reg(REG_ITER_LIMIT, 32'd1);
        add_random(15);
        add_sample(32'hF000_0000, 32'h0000_0000, 1'b1);
        drain();

        write_reg(REG_ITER_LIMIT, 32'd500);
        write_reg(REG_REC_START, 32'd10);
        write_reg(REG_SCALE_X, 32'h0080_8000);
        write_reg(REG_SCALE_Y, 32'h0123_4567);
        write_reg(REG_PIC_WIDTH, 32'd700);
        write_reg(REG_PIC_HEIGHT, 32'd333);
        add_random(40);
        drain();

        if (fails == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire
